/* hw/rtl/direct_mapped_hash_table_core_assert.svh */
// ----------------------------------------------------------------------------
// direct mapped hash table assertion macros
// checks that run on clk, switched off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_HASH_TABLE_CORE_ASSERT_SVH
`define DIRECT_MAPPED_HASH_TABLE_CORE_ASSERT_SVH

// condition in the same cycle
`define DMHT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dmht check failed");

// condition in the following cycle
`define DMHT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dmht check failed");

`endif

/* hw/rtl/dmht_pkg.sv */
// ----------------------------------------------------------------------------
// dmht_pkg
// shared types, codes and constants of the direct mapped hash table
// ----------------------------------------------------------------------------
package dmht_pkg;

	localparam int DEF_TABLE_DEPTH   = 256;
	localparam int DEF_MAX_KEY_BYTES = 8;

	localparam logic [63:0] HASH_MULT      = 64'd1099511628211;
	localparam logic [63:0] SEED_RESET     = 64'd14695981039346656037;
	localparam logic [8:0]  TSIZE_RESET    = 9'd256;
	localparam logic [3:0]  KBYTES_RESET   = 4'd8;

	localparam logic [2:0] MODE_INSERT    = 3'd0;
	localparam logic [2:0] MODE_LOOKUP    = 3'd1;
	localparam logic [2:0] MODE_CLR_SLOT  = 3'd2;
	localparam logic [2:0] MODE_CLR_VALUE = 3'd3;
	localparam logic [2:0] MODE_CLR_ALL   = 3'd4;

	localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
	localparam logic [1:0] REG_KEY_BYTES  = 2'd1;
	localparam logic [1:0] REG_HASH_SEED  = 2'd2;

	typedef struct packed {
		logic load;
		logic hash_step;
		logic mod_step;
		logic mem_rd;
		logic commit;
	} dmht_cmd_t;

	typedef struct packed {
		logic hash_req;
		logic hash_last;
		logic mod_last;
	} dmht_status_t;

endpackage

/* hw/rtl/direct_mapped_hash_table_core.sv */
// ----------------------------------------------------------------------------
// direct_mapped_hash_table_core
// fnv-1a 64 indexed key/value table with one slot per hash, no probing
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   config    cfg_we               cfg_index, cfg_wdata
//   command   start, busy          mode, key, data_word, slot_number
//   result    done                 hit, read_value, slot_used,
//                                  updated_existing, error, entry_count
//
// insert and lookup hash the key bytes one at a time, form the
// remainder bit-serially, then read the slot and commit. other modes
// only read the slot and commit. clear all drops the present
// bits of every slot below the table size in its commit cycle.
// start is taken again in the cycle that done is high. results cannot be
// stalled. reset needs no clearing pass.
module direct_mapped_hash_table_core #(
	parameter int TABLE_DEPTH   = dmht_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_KEY_BYTES = dmht_pkg::DEF_MAX_KEY_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [63:0] key,
	input  logic [63:0] data_word,
	input  logic [7:0]  slot_number,
	output logic        done,
	output logic        hit,
	output logic [63:0] read_value,
	output logic [7:0]  slot_used,
	output logic        updated_existing,
	output logic        error,
	output logic [31:0] entry_count
);
	import dmht_pkg::*;

	dmht_cmd_t    cmd;
	dmht_status_t status;

	dmht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	dmht_dpath #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.mode             (mode),
		.key              (key),
		.data_word        (data_word),
		.slot_number      (slot_number),
		.cmd              (cmd),
		.status           (status),
		.done             (done),
		.hit              (hit),
		.read_value       (read_value),
		.slot_used        (slot_used),
		.updated_existing (updated_existing),
		.error            (error),
		.entry_count      (entry_count)
	);

endmodule

/* hw/rtl/dmht_ctrl.sv */
// ----------------------------------------------------------------------------
// dmht_ctrl
// sequencer: hash bytes and reduce modulo table size (insert and lookup only), read slot, commit
// ----------------------------------------------------------------------------
module dmht_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  dmht_pkg::dmht_status_t status,
	output dmht_pkg::dmht_cmd_t    cmd
);
	import dmht_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_HASH   = 3'd1;
	localparam logic [2:0] S_MOD    = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = status.hash_req ? S_HASH : S_READ;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (status.hash_last) state_nxt = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (status.mod_last) state_nxt = S_READ;
			end
			S_READ: begin
				cmd.mem_rd = 1'b1;
				state_nxt  = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

endmodule

/* hw/rtl/dmht_dpath.sv */
// ----------------------------------------------------------------------------
// dmht_dpath
// config registers, fnv-1a hash, serial remainder, slot stores and results
// ----------------------------------------------------------------------------
`include "direct_mapped_hash_table_core_assert.svh"

module dmht_dpath #(
	parameter int TABLE_DEPTH   = dmht_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_KEY_BYTES = dmht_pkg::DEF_MAX_KEY_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [63:0]            cfg_wdata,
	input  logic [2:0]             mode,
	input  logic [63:0]            key,
	input  logic [63:0]            data_word,
	input  logic [7:0]             slot_number,
	input  dmht_pkg::dmht_cmd_t     cmd,
	output dmht_pkg::dmht_status_t  status,
	output logic                   done,
	output logic                   hit,
	output logic [63:0]            read_value,
	output logic [7:0]             slot_used,
	output logic                   updated_existing,
	output logic                   error,
	output logic [31:0]            entry_count
);
	import dmht_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// config
	logic [8:0]  tsize_q;
	logic [3:0]  kbytes_q;
	logic [63:0] seed_q;

	// item
	logic [2:0]  mode_q;
	logic [63:0] key_q;
	logic [63:0] data_q;
	logic [7:0]  slotn_q;
	logic [63:0] h_q;
	logic [8:0]  rem_q;
	logic [5:0]  cnt_q;
	logic [31:0] count_q;

	logic [63:0] key_mem [TABLE_DEPTH];
	logic [63:0] val_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] kpres_q;
	logic [TABLE_DEPTH-1:0] vpres_q;
	logic [63:0] key_rd_s;
	logic [63:0] val_rd_s;

	logic [8:0]  eff_size;
	logic [3:0]  eff_bytes;
	logic [63:0] kmask;
	logic [7:0]  hbyte;
	logic [63:0] hx;
	logic [63:0] h_nxt;
	logic [9:0]  r2;
	logic        is_hash_mode;
	logic        is_clr_mode;
	logic        slot_err;
	logic [AW-1:0] idx;
	logic        match;

	always_comb begin
		if (tsize_q == 9'd0) eff_size = 9'd1;
		else if (int'(tsize_q) > TABLE_DEPTH) eff_size = 9'(TABLE_DEPTH);
		else eff_size = tsize_q;
		if (kbytes_q == 4'd0) eff_bytes = 4'd1;
		else if (int'(kbytes_q) > MAX_KEY_BYTES) eff_bytes = 4'(MAX_KEY_BYTES);
		else eff_bytes = kbytes_q;
		for (int i = 0; i < 8; i++) begin
			kmask[i*8 +: 8] = (i < int'(eff_bytes)) ? 8'hff : 8'h00;
		end
	end

	// fnv prime is 2^40 + 2^8 + 0xb3: shifts and one narrow product
	assign hbyte = key_q[{cnt_q[2:0], 3'b000} +: 8];
	assign hx    = h_q ^ {56'd0, hbyte};
	assign h_nxt = (hx << 40) + (hx << 8) + (hx * 64'(HASH_MULT[7:0]));

	// one remainder bit per cycle, msb first
	always_comb begin
		r2 = {rem_q, h_q[63]};
		if (r2 >= {1'b0, eff_size}) r2 = r2 - {1'b0, eff_size};
	end

	assign is_hash_mode = (mode_q == MODE_INSERT) || (mode_q == MODE_LOOKUP);
	assign is_clr_mode  = (mode_q == MODE_CLR_SLOT) || (mode_q == MODE_CLR_VALUE);
	assign slot_err     = ({1'b0, slotn_q} >= eff_size);
	assign idx          = is_hash_mode ? AW'(rem_q) : AW'(slotn_q);
	assign match        = kpres_q[idx] && ((key_rd_s & kmask) == (key_q & kmask));

	assign status.hash_req  = (mode == MODE_INSERT) || (mode == MODE_LOOKUP);
	assign status.hash_last = (cnt_q[3:0] == eff_bytes - 4'd1);
	assign status.mod_last  = (cnt_q == 6'd63);
	assign entry_count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q  <= TSIZE_RESET;
			kbytes_q <= KBYTES_RESET;
			seed_q   <= SEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TABLE_SIZE: tsize_q  <= cfg_wdata[8:0];
				REG_KEY_BYTES:  kbytes_q <= cfg_wdata[3:0];
				REG_HASH_SEED:  seed_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			key_q   <= key;
			data_q  <= data_word;
			slotn_q <= slot_number;
			h_q     <= seed_q;
			rem_q   <= 9'd0;
		end else if (cmd.hash_step) begin
			h_q <= h_nxt;
		end else if (cmd.mod_step) begin
			h_q   <= {h_q[62:0], 1'b0};
			rem_q <= r2[8:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.load || (cmd.hash_step && status.hash_last)) cnt_q <= '0;
		else if (cmd.hash_step || cmd.mod_step) cnt_q <= cnt_q + 6'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			key_rd_s <= key_mem[idx];
			val_rd_s <= val_mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (mode_q == MODE_INSERT)) begin
			val_mem[idx] <= data_q;
			if (!match) key_mem[idx] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kpres_q <= '0;
			vpres_q <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			if (mode_q == MODE_INSERT) begin
				kpres_q[idx] <= 1'b1;
				vpres_q[idx] <= 1'b1;
				if (!match && (count_q != 32'hffff_ffff)) count_q <= count_q + 32'd1;
			end else if (is_clr_mode && !slot_err) begin
				vpres_q[idx] <= 1'b0;
				if (mode_q == MODE_CLR_SLOT) kpres_q[idx] <= 1'b0;
			end else if (mode_q == MODE_CLR_ALL) begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (i < int'(eff_size)) begin
						kpres_q[i] <= 1'b0;
						vpres_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cmd.commit;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit              <= (mode_q == MODE_LOOKUP) && match && vpres_q[idx];
			read_value       <= ((mode_q == MODE_LOOKUP) && match && vpres_q[idx])
				? val_rd_s : 64'd0;
			updated_existing <= (mode_q == MODE_INSERT) && match;
			error            <= is_clr_mode && slot_err;
			if (is_hash_mode) slot_used <= rem_q[7:0];
			else if (is_clr_mode) slot_used <= slotn_q;
			else slot_used <= 8'd0;
		end
	end

	`DMHT_ASSERT_NXT(a_done_single, done, !done)
	`DMHT_ASSERT_IMP(a_err_no_hit, done && error, !hit && !updated_existing)
	`DMHT_ASSERT_NXT(a_commit_done, cmd.commit, done)

endmodule
